/* sv/tma_pkg.sv */
`default_nettype none
package tma_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRANS_U_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_V_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_U_EN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_V_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_H   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_V   = 3'd6;

  // cordic: angles in turns with 32 fraction bits, vector in q30
  localparam int CORDIC_STEPS = 28;
  localparam int ITER_W       = 5;
  localparam int CZ_W         = 34;
  localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i in turns
  function automatic logic signed [CZ_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
    case (i)
      5'd0:    atan_turn = 34'sh20000000;
      5'd1:    atan_turn = 34'sh12E4051E;
      5'd2:    atan_turn = 34'sh09FB385B;
      5'd3:    atan_turn = 34'sh051111D4;
      5'd4:    atan_turn = 34'sh028B0D43;
      5'd5:    atan_turn = 34'sh0145D7E1;
      5'd6:    atan_turn = 34'sh00A2F61E;
      5'd7:    atan_turn = 34'sh00517C55;
      5'd8:    atan_turn = 34'sh0028BE53;
      5'd9:    atan_turn = 34'sh00145F2F;
      5'd10:   atan_turn = 34'sh000A2F98;
      5'd11:   atan_turn = 34'sh000517CC;
      5'd12:   atan_turn = 34'sh00028BE6;
      5'd13:   atan_turn = 34'sh000145F3;
      5'd14:   atan_turn = 34'sh0000A2FA;
      5'd15:   atan_turn = 34'sh0000517D;
      5'd16:   atan_turn = 34'sh000028BE;
      5'd17:   atan_turn = 34'sh0000145F;
      5'd18:   atan_turn = 34'sh00000A30;
      5'd19:   atan_turn = 34'sh00000518;
      5'd20:   atan_turn = 34'sh0000028C;
      5'd21:   atan_turn = 34'sh00000146;
      5'd22:   atan_turn = 34'sh000000A3;
      5'd23:   atan_turn = 34'sh00000051;
      5'd24:   atan_turn = 34'sh00000029;
      5'd25:   atan_turn = 34'sh00000014;
      5'd26:   atan_turn = 34'sh0000000A;
      5'd27:   atan_turn = 34'sh00000005;
      default: atan_turn = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* sv/tma_in_if.sv */
`default_nettype none
interface tma_in_if import tma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] anim_value;

  modport source (output valid, output anim_value, input ready);
  modport sink   (input valid, input anim_value, output ready);
endinterface
`default_nettype wire

/* sv/tma_out_if.sv */
`default_nettype none
interface tma_out_if import tma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] m00;
  logic signed [DATA_W-1:0] m01;
  logic signed [DATA_W-1:0] m02;
  logic signed [DATA_W-1:0] m10;
  logic signed [DATA_W-1:0] m11;
  logic signed [DATA_W-1:0] m12;
  logic signed [DATA_W-1:0] readback;
  logic                     scale_fault;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output readback, output scale_fault,
                  input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10,
                  input m11, input m12, input readback, input scale_fault,
                  output ready);
endinterface
`default_nettype wire

/* sv/texture_matrix_animator_core.sv */
`default_nettype none
// Texture matrix animator: each item on anim is a signed fixed-point animation
// value; one result item on mtx carries the 2x3 texture matrix, a readback word
// and a fault flag for a zero scale. The block takes one item at a time and is
// not ready until the item is done. All division goes through one restoring
// divider of FRAC_BITS+32 steps, sin/cos through one 28-step cordic loop, and
// the rotation through one shared multiplier. A non-tiled item with scale runs
// two reciprocal divisions; a tiled item runs three divisions for its frame and
// offsets, plus the two reciprocals unless both effective frame counts are one.
// The result sits in an output register, so the next item is taken while it
// waits. Configuration must be written only while no item is in flight; the
// block itself does not enforce this.
module texture_matrix_animator_core import tma_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_data,
  tma_in_if.sink              anim,
  tma_out_if.source           mtx
);

  localparam int DIV_W = FRAC_BITS + 32;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int MW    = 36;
  localparam int CS_W  = FRAC_BITS + 3;
  localparam int MB_W  = (CS_W > 17) ? CS_W : 17;
  localparam int P_W   = MW + MB_W;
  localparam int AW    = 40;
  localparam int T_W   = CS_W + 2;

  localparam logic [DATA_W-1:0]      ONE_U  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [MW-1:0]   ONE_M  = MW'(64'd1 << FRAC_BITS);
  localparam logic signed [T_W-1:0]  ONE_T  = T_W'(64'd1 << FRAC_BITS);
  localparam logic signed [P_W-1:0]  RND_P  = P_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [CZ_W-1:0] RND_C  = CZ_W'(64'd1 << (29 - FRAC_BITS));
  localparam logic [DIV_W-1:0]       RCP_N  = DIV_W'(64'd1 << (2 * FRAC_BITS));
  localparam logic [DIV_W-1:0]       MAX_D  = DIV_W'(64'h7FFF_FFFF);
  localparam logic [DIV_W-1:0]       HALF_D = DIV_W'(64'h8000_0000);
  localparam logic [DATA_W-1:0]      MAX_P  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]      MIN_N  = 32'h8000_0000;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TLD  = 4'd1;
  localparam logic [3:0] ST_TMOD = 4'd2;
  localparam logic [3:0] ST_UOFF = 4'd3;
  localparam logic [3:0] ST_VOFF = 4'd4;
  localparam logic [3:0] ST_SCL  = 4'd5;
  localparam logic [3:0] ST_RCPU = 4'd6;
  localparam logic [3:0] ST_RCPV = 4'd7;
  localparam logic [3:0] ST_OFFS = 4'd8;
  localparam logic [3:0] ST_CORD = 4'd9;
  localparam logic [3:0] ST_CFIN = 4'd10;
  localparam logic [3:0] ST_RSET = 4'd11;
  localparam logic [3:0] ST_ROT  = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  // configuration registers
  logic        trans_u_en, trans_v_en, scale_u_en, scale_v_en, rotate_en;
  logic [15:0] frames_h, frames_v;

  // animation state
  logic [DATA_W-1:0] u_offset, v_offset, u_scale, v_scale, rotation_turns;
  logic [15:0]       last_frame, vertical_frame;

  // sequencer
  logic [3:0] state;
  logic       tiled, t_neg, scale_on, fault, rot, flip;

  // divider
  logic [DIV_W-1:0] div_rem, div_quo, div_den;
  logic [CNT_W-1:0] div_cnt;
  logic             div_load;
  logic [DIV_W-1:0] div_num_in, div_den_in;
  logic [DIV_W:0]   div_sh, div_diff;
  logic             div_ge, div_done;

  // multiplier
  logic signed [MW-1:0]   mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod;

  // matrix before rotation
  logic signed [MW-1:0] m00_r, m11_r, m02_r, m12_r;

  // cordic
  logic signed [CZ_W-1:0] cx, cy, cz;
  logic [ITER_W-1:0]      iter;
  logic signed [CS_W-1:0] c_r, s_r;

  // rotation accumulators
  logic signed [AW-1:0] acc00, acc01, acc02, acc10, acc11, acc12;
  logic [3:0]           rk;

  // output register
  logic              ov;
  logic [DATA_W-1:0] o00, o01, o02, o10, o11, o12, orb;
  logic              ofault;

  // ---------------------------------------------------------------------------
  // helpers

  function automatic logic [DATA_W-1:0] sat32(input logic signed [AW-1:0] v);
    if (v > $signed(AW'(MAX_P)))
      sat32 = MAX_P;
    else if (v < -$signed(AW'(HALF_D)))
      sat32 = MIN_N;
    else
      sat32 = v[DATA_W-1:0];
  endfunction

  // reciprocal from divider quotient, clipped and signed
  function automatic logic [DATA_W-1:0] rcp(input logic [DIV_W-1:0] q,
                                            input logic neg, input logic zero);
    if (zero)
      rcp = MAX_P;
    else if (q >= HALF_D)
      rcp = neg ? MIN_N : MAX_P;
    else if (neg)
      rcp = DATA_W'(0) - q[DATA_W-1:0];
    else
      rcp = q[DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // scale operands

  logic [15:0]       v_eff;
  logic [32:0]       u_abs, v_abs;
  logic [DIV_W-1:0]  us_mag, vs_mag, h_sh, v_sh;
  logic              us_neg, vs_neg, us_zero, vs_zero, us_one, vs_one, scale_c;

  assign v_eff = (frames_v == 16'd0) ? 16'd1 : frames_v;
  assign h_sh  = DIV_W'(frames_h) << FRAC_BITS;
  assign v_sh  = DIV_W'(v_eff) << FRAC_BITS;
  assign u_abs = u_scale[DATA_W-1] ? 33'(-$signed({u_scale[DATA_W-1], u_scale}))
                                   : {1'b0, u_scale};
  assign v_abs = v_scale[DATA_W-1] ? 33'(-$signed({v_scale[DATA_W-1], v_scale}))
                                   : {1'b0, v_scale};

  always_comb begin
    if (tiled) begin
      us_mag = h_sh;
      vs_mag = v_sh;
      us_neg = 1'b0;
      vs_neg = 1'b0;
      us_one = (frames_h == 16'd1);
      vs_one = (v_eff == 16'd1);
    end else begin
      us_mag = DIV_W'(u_abs);
      vs_mag = DIV_W'(v_abs);
      us_neg = u_scale[DATA_W-1];
      vs_neg = v_scale[DATA_W-1];
      us_one = (u_scale == ONE_U);
      vs_one = (v_scale == ONE_U);
    end
    us_zero = (us_mag == '0);
    vs_zero = (vs_mag == '0);
    scale_c = !(us_one && vs_one);
  end

  // ---------------------------------------------------------------------------
  // tiled frame math

  logic [P_W-1:0]   prod_abs, prod_sh;
  logic [15:0]      rem16, fr, vf_new;
  logic             wrap;

  assign prod_abs = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
  assign prod_sh  = prod_abs >> FRAC_BITS;
  assign rem16    = div_rem[15:0];
  assign fr       = (t_neg && rem16 != 16'd0) ? frames_h - rem16 : rem16;
  assign wrap     = (last_frame == 16'd0) && (fr == frames_h - 16'd1);

  always_comb begin
    if (!wrap)
      vf_new = vertical_frame;
    else if (vertical_frame >= v_eff - 16'd1)
      vf_new = 16'd0;
    else
      vf_new = vertical_frame + 16'd1;
  end

  // ---------------------------------------------------------------------------
  // divider launch

  assign div_done = (div_cnt == '0);

  always_comb begin
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    case (state)
      ST_TLD: begin
        div_load   = 1'b1;
        div_num_in = prod_sh[DIV_W-1:0];
        div_den_in = DIV_W'(frames_h);
      end
      ST_TMOD: begin
        div_load   = div_done;
        div_num_in = (DIV_W'(fr) << FRAC_BITS) + DIV_W'(frames_h >> 1);
        div_den_in = DIV_W'(frames_h);
      end
      ST_UOFF: begin
        div_load   = div_done;
        div_num_in = (DIV_W'(vertical_frame) << FRAC_BITS) + DIV_W'(v_eff >> 1);
        div_den_in = DIV_W'(v_eff);
      end
      ST_SCL: begin
        div_load   = scale_c;
        div_num_in = RCP_N + (us_mag >> 1);
        div_den_in = us_mag;
      end
      ST_RCPU: begin
        div_load   = div_done;
        div_num_in = RCP_N + (vs_mag >> 1);
        div_den_in = vs_mag;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign div_sh   = {div_rem, div_quo[DIV_W-1]};
  assign div_ge   = (div_sh >= {1'b0, div_den});
  assign div_diff = div_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_rem <= '0;
      div_quo <= div_num_in;
      div_den <= div_den_in;
      div_cnt <= CNT_W'(DIV_W);
    end else if (!div_done) begin
      div_rem <= div_ge ? div_diff[DIV_W-1:0] : div_sh[DIV_W-1:0];
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier

  always_comb begin
    mul_a = MW'($signed(anim.anim_value));
    mul_b = MB_W'($signed({1'b0, frames_h}));
    if (state == ST_ROT) begin
      case (rk)
        4'd0:    begin mul_a = m00_r; mul_b = MB_W'(c_r); end
        4'd1:    begin mul_a = m11_r; mul_b = MB_W'(s_r); end
        4'd2:    begin mul_a = m02_r; mul_b = MB_W'(c_r); end
        4'd3:    begin mul_a = m12_r; mul_b = MB_W'(s_r); end
        4'd4:    begin mul_a = m00_r; mul_b = MB_W'(s_r); end
        4'd5:    begin mul_a = m11_r; mul_b = MB_W'(c_r); end
        4'd6:    begin mul_a = m02_r; mul_b = MB_W'(s_r); end
        4'd7:    begin mul_a = m12_r; mul_b = MB_W'(c_r); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rounded product in q form
  logic signed [P_W-1:0] prod_rnd, prod_q;
  logic signed [AW-1:0]  term;
  logic [3:0]            rk_prev;

  assign prod_rnd = prod + RND_P;
  assign prod_q   = prod_rnd >>> FRAC_BITS;
  assign term     = $signed(prod_q[AW-1:0]);
  assign rk_prev  = rk - 4'd1;

  // ---------------------------------------------------------------------------
  // cordic step and finish values

  logic signed [CZ_W-1:0] xs, ys, at, cx_r, cy_r;
  logic signed [CS_W-1:0] c_val, s_val;
  logic signed [MW-1:0]   base_u, base_v;
  logic signed [T_W-1:0]  tx, ty;
  logic [DATA_W-1:0]      phase, phase_q, phase_p;
  logic                   flip_c;

  assign xs    = cy >>> iter;
  assign ys    = cx >>> iter;
  assign at    = atan_turn(iter);
  assign cx_r  = (cx + RND_C) >>> (30 - FRAC_BITS);
  assign cy_r  = (cy + RND_C) >>> (30 - FRAC_BITS);
  assign c_val = cx_r[CS_W-1:0];
  assign s_val = cy_r[CS_W-1:0];

  assign phase   = rotation_turns << (DATA_W - FRAC_BITS);
  assign phase_q = phase + 32'h4000_0000;
  assign flip_c  = phase_q[DATA_W-1];
  assign phase_p = flip_c ? phase + 32'h8000_0000 : phase;

  assign base_u = (scale_on && !tiled) ? (ONE_M - m00_r) >>> 1 : MW'(0);
  assign base_v = (scale_on && !tiled) ? (ONE_M - m11_r) >>> 1 : MW'(0);
  assign tx     = (ONE_T - T_W'(c_r) + T_W'(s_r)) >>> 1;
  assign ty     = (ONE_T - T_W'(s_r) - T_W'(c_r)) >>> 1;

  // ---------------------------------------------------------------------------
  // sequencer

  logic fin_load;
  assign fin_load = (state == ST_FIN) && (!ov || mtx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      trans_u_en     <= 1'b0;
      trans_v_en     <= 1'b0;
      scale_u_en     <= 1'b0;
      scale_v_en     <= 1'b0;
      rotate_en      <= 1'b0;
      frames_h       <= 16'd0;
      frames_v       <= 16'd1;
      u_offset       <= '0;
      v_offset       <= '0;
      u_scale        <= ONE_U;
      v_scale        <= ONE_U;
      rotation_turns <= '0;
      last_frame     <= 16'd0;
      vertical_frame <= 16'd0;
      ov             <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_TRANS_U_EN: trans_u_en <= cfg_data[0];
          REG_TRANS_V_EN: trans_v_en <= cfg_data[0];
          REG_SCALE_U_EN: scale_u_en <= cfg_data[0];
          REG_SCALE_V_EN: scale_v_en <= cfg_data[0];
          REG_ROTATE_EN:  rotate_en  <= cfg_data[0];
          REG_FRAMES_H:   frames_h   <= cfg_data;
          REG_FRAMES_V:   frames_v   <= cfg_data;
          default:        ;
        endcase
      end

      // output handshake
      if (fin_load)
        ov <= 1'b1;
      else if (mtx.ready)
        ov <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (anim.valid) begin
            tiled <= (frames_h != 16'd0);
            fault <= 1'b0;
            if (frames_h != 16'd0) begin
              state <= ST_TLD;
            end else begin
              if (trans_u_en) u_offset       <= anim.anim_value;
              if (trans_v_en) v_offset       <= anim.anim_value;
              if (scale_u_en) u_scale        <= anim.anim_value;
              if (scale_v_en) v_scale        <= anim.anim_value;
              if (rotate_en)  rotation_turns <= anim.anim_value;
              state <= ST_SCL;
            end
          end
        end
        ST_TLD: begin
          t_neg <= prod[P_W-1];
          state <= ST_TMOD;
        end
        ST_TMOD: begin
          if (div_done) begin
            last_frame     <= fr;
            vertical_frame <= vf_new;
            state          <= ST_UOFF;
          end
        end
        ST_UOFF: begin
          if (div_done) begin
            u_offset <= div_quo[DATA_W-1:0];
            state    <= ST_VOFF;
          end
        end
        ST_VOFF: begin
          if (div_done) begin
            v_offset <= (div_quo > MAX_D) ? MAX_P : div_quo[DATA_W-1:0];
            u_scale  <= (h_sh > MAX_D) ? MAX_P : h_sh[DATA_W-1:0];
            v_scale  <= (v_sh > MAX_D) ? MAX_P : v_sh[DATA_W-1:0];
            state    <= ST_SCL;
          end
        end
        ST_SCL: begin
          scale_on <= scale_c;
          if (scale_c) begin
            state <= ST_RCPU;
          end else begin
            m00_r <= ONE_M;
            m11_r <= ONE_M;
            state <= ST_OFFS;
          end
        end
        ST_RCPU: begin
          if (div_done) begin
            m00_r <= MW'($signed(rcp(div_quo, us_neg, us_zero)));
            fault <= fault | us_zero;
            state <= ST_RCPV;
          end
        end
        ST_RCPV: begin
          if (div_done) begin
            m11_r <= MW'($signed(rcp(div_quo, vs_neg, vs_zero)));
            fault <= fault | vs_zero;
            state <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          m02_r <= base_u + MW'($signed(u_offset));
          m12_r <= base_v + MW'($signed(v_offset));
          rot   <= (rotation_turns != '0);
          cx    <= CORDIC_GAIN;
          cy    <= '0;
          cz    <= CZ_W'($signed(phase_p));
          flip  <= flip_c;
          iter  <= '0;
          state <= (rotation_turns != '0) ? ST_CORD : ST_FIN;
        end
        ST_CORD: begin
          if (!cz[CZ_W-1]) begin
            cx <= cx - xs;
            cy <= cy + ys;
            cz <= cz - at;
          end else begin
            cx <= cx + xs;
            cy <= cy - ys;
            cz <= cz + at;
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(CORDIC_STEPS - 1))
            state <= ST_CFIN;
        end
        ST_CFIN: begin
          c_r   <= flip ? -c_val : c_val;
          s_r   <= flip ? -s_val : s_val;
          state <= ST_RSET;
        end
        ST_RSET: begin
          acc00 <= '0;
          acc01 <= '0;
          acc02 <= AW'(tx);
          acc10 <= '0;
          acc11 <= '0;
          acc12 <= AW'(ty);
          rk    <= 4'd0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          // product of the previous step comes from the product register
          if (rk != 4'd0) begin
            case (rk_prev)
              4'd0:    acc00 <= acc00 + term;
              4'd1:    acc01 <= acc01 - term;
              4'd2:    acc02 <= acc02 + term;
              4'd3:    acc02 <= acc02 - term;
              4'd4:    acc10 <= acc10 + term;
              4'd5:    acc11 <= acc11 + term;
              4'd6:    acc12 <= acc12 + term;
              4'd7:    acc12 <= acc12 + term;
              default: ;
            endcase
          end
          rk <= rk + 4'd1;
          if (rk == 4'd8)
            state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_load)
            state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result assembly

  logic [DATA_W-1:0] r00, r01, r02, r10, r11, r12, rrb;

  always_comb begin
    if (rot) begin
      r00 = sat32(acc00);
      r01 = sat32(acc01);
      r02 = sat32(acc02);
      r10 = sat32(acc10);
      r11 = sat32(acc11);
      r12 = sat32(acc12);
    end else begin
      r00 = sat32(AW'(m00_r));
      r01 = '0;
      r02 = sat32(AW'(m02_r));
      r10 = '0;
      r11 = sat32(AW'(m11_r));
      r12 = sat32(AW'(m12_r));
    end
    if (trans_u_en)
      rrb = r02;
    else if (trans_v_en)
      rrb = r12;
    else if (scale_u_en)
      rrb = r00;
    else if (scale_v_en)
      rrb = r11;
    else
      rrb = '0;
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      o00    <= r00;
      o01    <= r01;
      o02    <= r02;
      o10    <= r10;
      o11    <= r11;
      o12    <= r12;
      orb    <= rrb;
      ofault <= fault;
    end
  end

  assign anim.ready      = (state == ST_IDLE);
  assign mtx.valid       = ov;
  assign mtx.m00         = o00;
  assign mtx.m01         = o01;
  assign mtx.m02         = o02;
  assign mtx.m10         = o10;
  assign mtx.m11         = o11;
  assign mtx.m12         = o12;
  assign mtx.readback    = orb;
  assign mtx.scale_fault = ofault;

endmodule
`default_nettype wire

/* sv/tma_checker.sv */
`default_nettype none
module tma_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_fault
);

  // a result waiting on the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: no item taken right after another
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result keeps its fault flag
  a_fault_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_fault))
    else $error("fault flag changed while stalled");

endmodule

bind texture_matrix_animator_core tma_checker u_tma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (anim.valid),
  .in_ready  (anim.ready),
  .out_valid (mtx.valid),
  .out_ready (mtx.ready),
  .out_fault (mtx.scale_fault)
);
`default_nettype wire
